FILE: rtl/byte_stream_lexer_defines.svh
// Assertion helpers used by the lexer top level.
`ifndef BYTE_STREAM_LEXER_DEFINES_SVH
`define BYTE_STREAM_LEXER_DEFINES_SVH

// Same-cycle implication.
`define BSL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BSL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bsl_pkg.sv
`timescale 1ns / 1ps
package bsl_pkg;

   localparam int MAX_TEXT_DEF = 32;
   localparam int LEN_W   = 6;
   localparam int LINE_W  = 20;
   localparam int INT_W   = 31;
   localparam int FRAC_W  = 30;
   localparam int FLEN_W  = 4;
   localparam int KIND_W  = 6;
   localparam int EC_W    = 3;
   localparam int CHAR_W  = 8;
   localparam int NUM_KW  = 10;
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;
   localparam int Q_CW    = 3;

   localparam logic [INT_W-1:0]  INT_SAT  = '1;
   localparam logic [LINE_W-1:0] LINE_SAT = '1;
   localparam logic [FLEN_W-1:0] FRAC_DIGITS_MAX = 4'd9;

   localparam logic [KIND_W-1:0] K_ID        = 6'd0;
   localparam logic [KIND_W-1:0] K_TYPE_INT  = 6'd1;
   localparam logic [KIND_W-1:0] K_TYPE_REAL = 6'd2;
   localparam logic [KIND_W-1:0] K_VAR       = 6'd3;
   localparam logic [KIND_W-1:0] K_FUNCTION  = 6'd4;
   localparam logic [KIND_W-1:0] K_IF        = 6'd5;
   localparam logic [KIND_W-1:0] K_ELSE      = 6'd6;
   localparam logic [KIND_W-1:0] K_WHILE     = 6'd7;
   localparam logic [KIND_W-1:0] K_END       = 6'd8;
   localparam logic [KIND_W-1:0] K_RETURN    = 6'd9;
   localparam logic [KIND_W-1:0] K_TYPE_STR  = 6'd10;
   localparam logic [KIND_W-1:0] K_COMMA     = 6'd11;
   localparam logic [KIND_W-1:0] K_FINISH    = 6'd12;
   localparam logic [KIND_W-1:0] K_COLON     = 6'd13;
   localparam logic [KIND_W-1:0] K_SEMI      = 6'd14;
   localparam logic [KIND_W-1:0] K_LPAR      = 6'd15;
   localparam logic [KIND_W-1:0] K_RPAR      = 6'd16;
   localparam logic [KIND_W-1:0] K_ADD       = 6'd17;
   localparam logic [KIND_W-1:0] K_SUB       = 6'd18;
   localparam logic [KIND_W-1:0] K_MUL       = 6'd19;
   localparam logic [KIND_W-1:0] K_DIV       = 6'd20;
   localparam logic [KIND_W-1:0] K_AND       = 6'd21;
   localparam logic [KIND_W-1:0] K_OR        = 6'd22;
   localparam logic [KIND_W-1:0] K_NOT       = 6'd23;
   localparam logic [KIND_W-1:0] K_ASSIGN    = 6'd24;
   localparam logic [KIND_W-1:0] K_EQUAL     = 6'd25;
   localparam logic [KIND_W-1:0] K_NOTEQ     = 6'd26;
   localparam logic [KIND_W-1:0] K_LESS      = 6'd27;
   localparam logic [KIND_W-1:0] K_GREATER   = 6'd28;
   localparam logic [KIND_W-1:0] K_GREATEREQ = 6'd29;
   localparam logic [KIND_W-1:0] K_REAL      = 6'd30;
   localparam logic [KIND_W-1:0] K_INT       = 6'd31;
   localparam logic [KIND_W-1:0] K_STRING    = 6'd32;
   localparam logic [KIND_W-1:0] K_ERROR     = 6'd33;

   localparam logic [EC_W-1:0] E_NONE     = 3'd0;
   localparam logic [EC_W-1:0] E_TOO_LONG = 3'd1;
   localparam logic [EC_W-1:0] E_AMP      = 3'd2;
   localparam logic [EC_W-1:0] E_BAR      = 3'd3;
   localparam logic [EC_W-1:0] E_DOT      = 3'd4;
   localparam logic [EC_W-1:0] E_STRING   = 3'd5;
   localparam logic [EC_W-1:0] E_BAD_CHAR = 3'd6;

   localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
   localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
   localparam logic [CHAR_W-1:0] CH_AMP    = 8'h26;
   localparam logic [CHAR_W-1:0] CH_LPAR   = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAR   = 8'h29;
   localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
   localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
   localparam logic [CHAR_W-1:0] CH_BAR    = 8'h7C;

   typedef enum logic [3:0] {
      M_IDLE, M_COMMENT, M_EQ, M_AMP, M_BAR, M_BANG, M_GT,
      M_IDENT, M_INT, M_DOT, M_FRAC, M_STR, M_HALT
   } scan_mode_type;

   typedef enum logic [1:0] {B_IDLE, B_READ, B_SEND} back_state_type;

   typedef struct packed {
      logic                is_run;
      logic [KIND_W-1:0]   kind;
      logic [LINE_W-1:0]   line;
      logic [INT_W-1:0]    iv;
      logic [FRAC_W-1:0]   fv;
      logic [FLEN_W-1:0]   fl;
      logic [EC_W-1:0]     ec;
      logic [LEN_W-1:0]    len;
   } cmd_type;

   typedef struct packed {
      logic            text_busy;
      logic [Q_CW-1:0] count;
   } front_status_type;

   typedef struct packed {
      logic q_pop;
      logic run_done;
   } back_ctrl_type;

   function automatic cmd_type make_cmd(input logic [KIND_W-1:0] kind,
                                        input logic [LINE_W-1:0] line,
                                        input logic [EC_W-1:0]   ec);
      cmd_type c;
      c        = '0;
      c.kind   = kind;
      c.line   = line;
      c.ec     = ec;
      return c;
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_word(input logic [CHAR_W-1:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
             || (c == CH_UNDER) || is_digit(c);
   endfunction

   // keyword text, first char in the top byte, zero padded
   function automatic logic [63:0] kw_word(input int k);
      logic [63:0] w;
      unique case (k)
         0: w = {"int", 40'd0};
         1: w = {"real", 32'd0};
         2: w = {"str", 40'd0};
         3: w = {"var", 40'd0};
         4: w = "function";
         5: w = {"if", 48'd0};
         6: w = {"else", 32'd0};
         7: w = {"while", 24'd0};
         8: w = {"end", 40'd0};
         default: w = {"return", 16'd0};
      endcase
      return w;
   endfunction

   function automatic logic [LEN_W-1:0] kw_len(input int k);
      logic [LEN_W-1:0] l;
      unique case (k)
         0, 2, 3, 8: l = 6'd3;
         1, 6:       l = 6'd4;
         4:          l = 6'd8;
         5:          l = 6'd2;
         7:          l = 6'd5;
         default:    l = 6'd6;
      endcase
      return l;
   endfunction

   function automatic logic [KIND_W-1:0] kw_kind(input int k);
      logic [KIND_W-1:0] r;
      unique case (k)
         0: r = K_TYPE_INT;
         1: r = K_TYPE_REAL;
         2: r = K_TYPE_STR;
         3: r = K_VAR;
         4: r = K_FUNCTION;
         5: r = K_IF;
         6: r = K_ELSE;
         7: r = K_WHILE;
         8: r = K_END;
         default: r = K_RETURN;
      endcase
      return r;
   endfunction

   // keywords whose character at pos equals c
   function automatic logic [NUM_KW-1:0] kw_hit(input logic [LEN_W-1:0] pos,
                                                input logic [CHAR_W-1:0] c);
      logic [NUM_KW-1:0] h;
      logic [63:0]       w;
      for (int k = 0; k < NUM_KW; k++) begin
         w    = kw_word(k);
         h[k] = (pos < 6'd8) && (w[63 - 8*pos[2:0] -: 8] == c);
      end
      return h;
   endfunction

endpackage

FILE: rtl/bsl_ram.sv
`timescale 1ns / 1ps
module bsl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bsl_front.sv
`timescale 1ns / 1ps
module bsl_front import bsl_pkg::*; #(
   parameter int MAX_TEXT = MAX_TEXT_DEF,
   parameter int AW       = $clog2(MAX_TEXT)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [CHAR_W-1:0]  req_char_in,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic [CHAR_W-1:0]  wr_data,
   output logic               q_valid,
   output cmd_type            q_head,
   input  back_ctrl_type      back_ctrl,
   output front_status_type   status
);

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TEXT);

   scan_mode_type        mode_ff, mode_in;
   logic [LINE_W-1:0]    line_ff, line_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [NUM_KW-1:0]    kwm_ff, kwm_in;
   logic [INT_W-1:0]     acc_ff, acc_in;
   logic [FRAC_W-1:0]    frac_ff, frac_in;
   logic [FLEN_W-1:0]    fcnt_ff, fcnt_in;
   logic                 busy_ff;
   cmd_type              q_mem_ff [Q_DEPTH];
   logic [Q_AW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [Q_CW-1:0]      count_ff;

   logic                 accept;
   logic                 e1_v, e2_v, again, app;
   cmd_type              e1, e2;
   logic [LEN_W-1:0]     app_len;
   logic [NUM_KW-1:0]    app_kwm;
   logic [3:0]           dig;
   logic [34:0]          acc_ext;
   logic                 kw_found;
   logic [KIND_W-1:0]    kw_sel;

   assign accept = push && !full;
   assign full   = busy_ff || (count_ff > Q_CW'(Q_DEPTH - 2));
   assign dig    = req_char_in[3:0];
   assign acc_ext = 35'(acc_ff) * 35'd10 + 35'(dig);

   always_comb begin
      kw_found = 1'b0;
      kw_sel   = K_ID;
      for (int k = 0; k < NUM_KW; k++) begin
         if (kwm_ff[k] && (len_ff == kw_len(k))) begin
            kw_found = 1'b1;
            kw_sel   = kw_kind(k);
         end
      end
   end

   always_comb begin
      mode_in = mode_ff;
      line_in = line_ff;
      len_in  = len_ff;
      kwm_in  = kwm_ff;
      acc_in  = acc_ff;
      frac_in = frac_ff;
      fcnt_in = fcnt_ff;
      e1_v    = 1'b0;
      e2_v    = 1'b0;
      e1      = make_cmd(K_ERROR, line_ff, E_NONE);
      e2      = make_cmd(K_ERROR, line_ff, E_NONE);
      again   = 1'b0;
      app     = 1'b0;
      app_len = len_ff;
      app_kwm = kwm_ff;

      unique case (mode_ff)
         M_HALT: begin
         end
         M_COMMENT: begin
            again = (req_char_in == CH_NL) || (req_char_in == CH_NUL);
         end
         M_EQ, M_BANG, M_GT: begin
            e1_v = 1'b1;
            if (req_char_in == CH_EQ) begin
               mode_in = M_IDLE;
               e1.kind = (mode_ff == M_EQ) ? K_EQUAL :
                         (mode_ff == M_BANG) ? K_NOTEQ : K_GREATEREQ;
            end else begin
               again   = 1'b1;
               e1.kind = (mode_ff == M_EQ) ? K_ASSIGN :
                         (mode_ff == M_BANG) ? K_NOT : K_GREATER;
            end
         end
         M_AMP, M_BAR: begin
            e1_v = 1'b1;
            if ((mode_ff == M_AMP && req_char_in == CH_AMP)
                || (mode_ff == M_BAR && req_char_in == CH_BAR)) begin
               mode_in = M_IDLE;
               e1.kind = (mode_ff == M_AMP) ? K_AND : K_OR;
            end else begin
               mode_in = M_HALT;
               e1.ec   = (mode_ff == M_AMP) ? E_AMP : E_BAR;
            end
         end
         M_IDENT: begin
            if (is_word(req_char_in)) begin
               app = 1'b1;
            end else if (len_ff > MAX_LEN) begin
               e1_v    = 1'b1;
               e1.ec   = E_TOO_LONG;
               mode_in = M_HALT;
            end else begin
               e1_v  = 1'b1;
               again = 1'b1;
               if (kw_found) begin
                  e1.kind = kw_sel;
               end else begin
                  e1.kind   = K_ID;
                  e1.is_run = 1'b1;
                  e1.len    = len_ff;
               end
            end
         end
         M_INT: begin
            if (is_digit(req_char_in)) begin
               acc_in = (acc_ext > 35'(INT_SAT)) ? INT_SAT : acc_ext[INT_W-1:0];
            end else if (req_char_in == CH_DOT) begin
               mode_in = M_DOT;
            end else begin
               e1_v    = 1'b1;
               e1.kind = K_INT;
               e1.iv   = acc_ff;
               again   = 1'b1;
            end
         end
         M_DOT: begin
            if (is_digit(req_char_in)) begin
               frac_in = FRAC_W'(dig);
               fcnt_in = 4'd1;
               mode_in = M_FRAC;
            end else begin
               e1_v    = 1'b1;
               e1.ec   = E_DOT;
               mode_in = M_HALT;
            end
         end
         M_FRAC: begin
            if (is_digit(req_char_in)) begin
               if (fcnt_ff < FRAC_DIGITS_MAX) begin
                  frac_in = FRAC_W'(frac_ff * 30'd10 + FRAC_W'(dig));
                  fcnt_in = fcnt_ff + 4'd1;
               end
            end else begin
               e1_v    = 1'b1;
               e1.kind = K_REAL;
               e1.iv   = acc_ff;
               e1.fv   = frac_ff;
               e1.fl   = fcnt_ff;
               again   = 1'b1;
            end
         end
         M_STR: begin
            if (req_char_in == CH_QUOTE) begin
               mode_in = M_IDLE;
               e1_v    = 1'b1;
               if (len_ff > MAX_LEN) begin
                  e1.ec   = E_TOO_LONG;
                  mode_in = M_HALT;
               end else begin
                  e1.kind   = K_STRING;
                  e1.is_run = (len_ff != '0);
                  e1.len    = len_ff;
               end
            end else if (req_char_in == CH_NUL) begin
               e1_v    = 1'b1;
               e1.ec   = E_STRING;
               mode_in = M_HALT;
            end else begin
               app = 1'b1;
            end
         end
         default: begin
            again = 1'b1;
         end
      endcase

      if (again) begin
         mode_in = M_IDLE;
         e2_v    = 1'b1;
         unique case (req_char_in)
            CH_SPACE, CH_TAB, CH_CR: e2_v = 1'b0;
            CH_NL: begin
               e2_v = 1'b0;
               if (line_ff != LINE_SAT) begin
                  line_in = line_ff + 20'd1;
               end
            end
            CH_HASH:  begin e2_v = 1'b0; mode_in = M_COMMENT; end
            CH_EQ:    begin e2_v = 1'b0; mode_in = M_EQ; end
            CH_AMP:   begin e2_v = 1'b0; mode_in = M_AMP; end
            CH_BAR:   begin e2_v = 1'b0; mode_in = M_BAR; end
            CH_BANG:  begin e2_v = 1'b0; mode_in = M_BANG; end
            CH_GT:    begin e2_v = 1'b0; mode_in = M_GT; end
            CH_QUOTE: begin e2_v = 1'b0; len_in = '0; mode_in = M_STR; end
            CH_NUL:   e2.kind = K_FINISH;
            CH_COMMA: e2.kind = K_COMMA;
            CH_COLON: e2.kind = K_COLON;
            CH_SEMI:  e2.kind = K_SEMI;
            CH_LPAR:  e2.kind = K_LPAR;
            CH_RPAR:  e2.kind = K_RPAR;
            CH_PLUS:  e2.kind = K_ADD;
            CH_MINUS: e2.kind = K_SUB;
            CH_STAR:  e2.kind = K_MUL;
            CH_SLASH: e2.kind = K_DIV;
            CH_LT:    e2.kind = K_LESS;
            default: begin
               if (is_digit(req_char_in)) begin
                  e2_v    = 1'b0;
                  acc_in  = INT_W'(dig);
                  frac_in = '0;
                  fcnt_in = '0;
                  mode_in = M_INT;
               end else if (is_word(req_char_in)) begin
                  e2_v    = 1'b0;
                  app     = 1'b1;
                  app_len = '0;
                  app_kwm = '1;
                  mode_in = M_IDENT;
               end else begin
                  e2.ec   = E_BAD_CHAR;
                  mode_in = M_HALT;
               end
            end
         endcase
      end

      wr_en   = 1'b0;
      wr_addr = app_len[AW-1:0];
      wr_data = req_char_in;
      if (app) begin
         wr_en  = accept && (app_len < MAX_LEN);
         len_in = (app_len <= MAX_LEN) ? app_len + 6'd1 : app_len;
         kwm_in = app_kwm & kw_hit(app_len, req_char_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         line_ff <= 20'd1;
         len_ff  <= '0;
         acc_ff  <= '0;
         frac_ff <= '0;
         fcnt_ff <= '0;
         kwm_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         len_ff  <= len_in;
         acc_ff  <= acc_in;
         frac_ff <= frac_in;
         fcnt_ff <= fcnt_in;
         kwm_ff  <= kwm_in;
      end
   end

   // command queue, up to two pushes and one pop per cycle
   logic [1:0] n_push;
   assign n_push = accept ? ({1'b0, e1_v} + {1'b0, e2_v}) : 2'd0;

   always_ff @(posedge clock) begin
      if (accept && e1_v) begin
         q_mem_ff[wr_ptr_ff] <= e1;
      end
      if (accept && e2_v) begin
         q_mem_ff[wr_ptr_ff + Q_AW'(e1_v)] <= e2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         busy_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + Q_AW'(n_push);
         rd_ptr_ff <= rd_ptr_ff + Q_AW'(back_ctrl.q_pop);
         count_ff  <= count_ff + Q_CW'(n_push) - Q_CW'(back_ctrl.q_pop);
         if (accept && e1_v && e1.is_run) begin
            busy_ff <= 1'b1;
         end else if (back_ctrl.run_done) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign q_valid          = (count_ff != '0);
   assign q_head           = q_mem_ff[rd_ptr_ff];
   assign status.text_busy = busy_ff;
   assign status.count     = count_ff;

endmodule

FILE: rtl/bsl_back.sv
`timescale 1ns / 1ps
module bsl_back import bsl_pkg::*; #(
   parameter int MAX_TEXT = MAX_TEXT_DEF,
   parameter int AW       = $clog2(MAX_TEXT)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  cmd_type            q_head,
   output back_ctrl_type      back_ctrl,
   output logic [AW-1:0]      rd_addr,
   input  logic [CHAR_W-1:0]  rd_data,
   output logic               empty,
   input  logic               pop,
   output logic [KIND_W-1:0]  rsp_token_kind,
   output logic [LINE_W-1:0]  rsp_line_number,
   output logic [INT_W-1:0]   rsp_int_value,
   output logic [FRAC_W-1:0]  rsp_fraction_value,
   output logic [FLEN_W-1:0]  rsp_fraction_length,
   output logic [CHAR_W-1:0]  rsp_text_char,
   output logic [LEN_W-1:0]   rsp_text_position,
   output logic [EC_W-1:0]    rsp_error_code,
   output logic               rsp_last_of_run
);

   back_state_type     state_ff, state_in;
   logic [LEN_W-1:0]   pos_ff, pos_in;
   logic               out_valid_ff, out_valid_in;
   logic               slot_free, load, last_char;
   cmd_type            o_cmd;
   logic [CHAR_W-1:0]  o_char;
   logic [LEN_W-1:0]   o_pos;
   logic               o_last;

   assign slot_free = !out_valid_ff || pop;
   assign last_char = (pos_ff == LEN_W'(q_head.len - 6'd1));
   assign rd_addr   = pos_ff[AW-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid && q_head.is_run) begin
               state_in = B_READ;
            end
         end
         B_READ: state_in = B_SEND;
         B_SEND: begin
            if (slot_free) begin
               state_in = last_char ? B_IDLE : B_READ;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      back_ctrl = '0;
      load      = 1'b0;
      pos_in    = pos_ff;
      o_cmd     = q_head;
      o_char    = '0;
      o_pos     = '0;
      o_last    = 1'b1;
      unique case (state_ff)
         B_IDLE: begin
            pos_in = '0;
            if (q_valid && !q_head.is_run && slot_free) begin
               load            = 1'b1;
               back_ctrl.q_pop = 1'b1;
            end
         end
         B_READ: begin
         end
         B_SEND: begin
            if (slot_free) begin
               load   = 1'b1;
               o_char = rd_data;
               o_pos  = pos_ff;
               o_last = last_char;
               pos_in = pos_ff + 6'd1;
               if (last_char) begin
                  back_ctrl.q_pop    = 1'b1;
                  back_ctrl.run_done = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      out_valid_in = load || (out_valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_token_kind      <= o_cmd.kind;
         rsp_line_number     <= o_cmd.line;
         rsp_int_value       <= o_cmd.iv;
         rsp_fraction_value  <= o_cmd.fv;
         rsp_fraction_length <= o_cmd.fl;
         rsp_error_code      <= o_cmd.ec;
         rsp_text_char       <= o_char;
         rsp_text_position   <= o_pos;
         rsp_last_of_run     <= o_last;
      end
   end

   assign empty = !out_valid_ff;

endmodule

FILE: rtl/byte_stream_lexer.sv
`timescale 1ns / 1ps
// channel | ports                                  | handshake
// input   | req_char_in                            | push / full
// result  | rsp_token_kind .. rsp_last_of_run      | empty / pop
//
// One source byte per cycle while no identifier or string run is pending.
// A run of N characters takes one text RAM read per character;
// input is held off (full) from the closing byte until the run has drained.
// Reset (synchronous) returns to idle with line count one.
// full also rises when the four-entry token queue cannot take two tokens.
`include "byte_stream_lexer_defines.svh"
module byte_stream_lexer import bsl_pkg::*; #(
   parameter int MAX_TEXT = MAX_TEXT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [CHAR_W-1:0]  req_char_in,
   output logic               empty,
   input  logic               pop,
   output logic [KIND_W-1:0]  rsp_token_kind,
   output logic [LINE_W-1:0]  rsp_line_number,
   output logic [INT_W-1:0]   rsp_int_value,
   output logic [FRAC_W-1:0]  rsp_fraction_value,
   output logic [FLEN_W-1:0]  rsp_fraction_length,
   output logic [CHAR_W-1:0]  rsp_text_char,
   output logic [LEN_W-1:0]   rsp_text_position,
   output logic [EC_W-1:0]    rsp_error_code,
   output logic               rsp_last_of_run
);

   localparam int AW = $clog2(MAX_TEXT);

   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [CHAR_W-1:0]  wr_data, rd_data;
   logic               q_valid;
   cmd_type            q_head;
   back_ctrl_type      back_ctrl;
   front_status_type   status;

   bsl_front #(.MAX_TEXT(MAX_TEXT), .AW(AW)) u_front (
      .clock, .reset, .push, .full, .req_char_in,
      .wr_en, .wr_addr, .wr_data,
      .q_valid, .q_head, .back_ctrl, .status
   );

   bsl_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_TEXT), .AW(AW)) u_text (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   bsl_back #(.MAX_TEXT(MAX_TEXT), .AW(AW)) u_back (
      .clock, .reset, .q_valid, .q_head, .back_ctrl, .rd_addr, .rd_data,
      .empty, .pop,
      .rsp_token_kind, .rsp_line_number, .rsp_int_value, .rsp_fraction_value,
      .rsp_fraction_length, .rsp_text_char, .rsp_text_position,
      .rsp_error_code, .rsp_last_of_run
   );

   `BSL_ASSERT_NOW(a_pop_has_item, clock, reset, back_ctrl.q_pop, q_valid, "pop of empty queue")
   `BSL_ASSERT_NOW(a_done_while_busy, clock, reset, back_ctrl.run_done, status.text_busy, "run done without run")
   `BSL_ASSERT_NEXT(a_busy_clears, clock, reset, back_ctrl.run_done, !status.text_busy, "busy stuck")
   `BSL_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, status.count <= Q_CW'(Q_DEPTH), "queue overflow")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import bsl_pkg::*;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [LINE_W-1:0] line;
      logic [INT_W-1:0]  ival;
      logic [FRAC_W-1:0] fval;
      logic [FLEN_W-1:0] flen;
      logic [CHAR_W-1:0] ch;
      logic [LEN_W-1:0]  pos;
      logic [EC_W-1:0]   ec;
      logic              last;
   } token_type;

   localparam int TEXT_MAX   = MAX_TEXT_DEF;
   localparam int WATCHDOG   = 4000;
   localparam int HOLD_AT    = 20;
   localparam int HOLD_LEN   = 400;
   localparam int PAUSE_AT   = 120;
   localparam int ITEM_GOAL  = 230;
   localparam longint INT_TOP = 64'd2147483647;

   logic              clock = 0;
   logic              reset = 1;
   logic              push = 0;
   logic              full;
   logic [CHAR_W-1:0] req_char_in = '0;
   logic              empty;
   logic              pop = 0;
   logic [KIND_W-1:0] rsp_token_kind;
   logic [LINE_W-1:0] rsp_line_number;
   logic [INT_W-1:0]  rsp_int_value;
   logic [FRAC_W-1:0] rsp_fraction_value;
   logic [FLEN_W-1:0] rsp_fraction_length;
   logic [CHAR_W-1:0] rsp_text_char;
   logic [LEN_W-1:0]  rsp_text_position;
   logic [EC_W-1:0]   rsp_error_code;
   logic              rsp_last_of_run;

   byte_stream_lexer u_top (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // source bytes still to send and tokens still to arrive
   logic [CHAR_W-1:0] source_q[$];
   token_type         token_q[$];
   int                errors = 0;
   int                accepted = 0;
   int                total_items = 1;

   // lexer shadow state
   scan_mode_type     mode = M_IDLE;
   logic [LINE_W-1:0] line_cnt = 1;
   logic [CHAR_W-1:0] tbuf[TEXT_MAX];
   int                tlen = 0;
   longint            iacc = 0;
   longint            facc = 0;
   int                fcnt = 0;

   string             kw_names[10] = '{"int", "real", "str", "var", "function",
                                       "if", "else", "while", "end", "return"};
   logic [KIND_W-1:0] kw_kinds[10] = '{K_TYPE_INT, K_TYPE_REAL, K_TYPE_STR, K_VAR,
                                       K_FUNCTION, K_IF, K_ELSE, K_WHILE, K_END,
                                       K_RETURN};

   function automatic bit is_num(logic [CHAR_W-1:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_letter(logic [CHAR_W-1:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
   endfunction

   task automatic add_token(logic [KIND_W-1:0] kind, longint iv, longint fv, int fl,
                            logic [CHAR_W-1:0] ch, int pos, logic [EC_W-1:0] ec,
                            bit last);
      token_type t;
      t.kind = kind; t.line = line_cnt; t.ival = INT_W'(iv); t.fval = FRAC_W'(fv);
      t.flen = FLEN_W'(fl);
      t.ch = ch; t.pos = LEN_W'(pos); t.ec = ec; t.last = last;
      token_q.push_back(t);
   endtask

   task automatic add_simple(logic [KIND_W-1:0] kind);
      add_token(kind, 0, 0, 0, 0, 0, E_NONE, 1);
   endtask

   task automatic add_error(logic [EC_W-1:0] ec);
      add_token(K_ERROR, 0, 0, 0, 0, 0, ec, 1);
      mode = M_HALT;
   endtask

   task automatic append_text(logic [CHAR_W-1:0] c);
      if (tlen < TEXT_MAX) tbuf[tlen] = c;
      if (tlen <= TEXT_MAX) tlen++;
   endtask

   task automatic emit_text(logic [KIND_W-1:0] kind);
      if (tlen > TEXT_MAX) add_error(E_TOO_LONG);
      else if (tlen == 0) add_simple(kind);
      else
         for (int i = 0; i < tlen; i++)
            add_token(kind, 0, 0, 0, tbuf[i], i, E_NONE, i + 1 == tlen);
   endtask

   task automatic close_ident();
      string s;
      s = "";
      if (tlen <= TEXT_MAX) begin
         for (int i = 0; i < tlen; i++) s = {s, string'(tbuf[i])};
         for (int k = 0; k < 10; k++)
            if (s == kw_names[k]) begin
               add_simple(kw_kinds[k]);
               return;
            end
      end
      emit_text(K_ID);
   endtask

   task automatic scan_start(logic [CHAR_W-1:0] c);
      mode = M_IDLE;
      case (c)
         CH_SPACE, CH_TAB, CH_CR: ;
         CH_NL: if (line_cnt != LINE_SAT) line_cnt++;
         CH_HASH:  mode = M_COMMENT;
         CH_NUL:   add_simple(K_FINISH);
         CH_COMMA: add_simple(K_COMMA);
         CH_COLON: add_simple(K_COLON);
         CH_SEMI:  add_simple(K_SEMI);
         CH_LPAR:  add_simple(K_LPAR);
         CH_RPAR:  add_simple(K_RPAR);
         CH_PLUS:  add_simple(K_ADD);
         CH_MINUS: add_simple(K_SUB);
         CH_STAR:  add_simple(K_MUL);
         CH_SLASH: add_simple(K_DIV);
         CH_LT:    add_simple(K_LESS);
         CH_EQ:    mode = M_EQ;
         CH_AMP:   mode = M_AMP;
         CH_BAR:   mode = M_BAR;
         CH_BANG:  mode = M_BANG;
         CH_GT:    mode = M_GT;
         CH_QUOTE: begin
            tlen = 0;
            mode = M_STR;
         end
         default: begin
            if (is_letter(c)) begin
               tlen = 0;
               append_text(c);
               mode = M_IDENT;
            end else if (is_num(c)) begin
               iacc = c - "0";
               facc = 0;
               fcnt = 0;
               mode = M_INT;
            end else add_error(E_BAD_CHAR);
         end
      endcase
   endtask

   task automatic lex_byte(logic [CHAR_W-1:0] c);
      bit again;
      longint d;
      again = 0;
      d = c - "0";
      case (mode)
         M_HALT: return;
         M_COMMENT: again = (c == CH_NL || c == CH_NUL);
         M_EQ:
            if (c == CH_EQ) begin add_simple(K_EQUAL); mode = M_IDLE; end
            else begin add_simple(K_ASSIGN); again = 1; end
         M_AMP:
            if (c == CH_AMP) begin add_simple(K_AND); mode = M_IDLE; end
            else add_error(E_AMP);
         M_BAR:
            if (c == CH_BAR) begin add_simple(K_OR); mode = M_IDLE; end
            else add_error(E_BAR);
         M_BANG:
            if (c == CH_EQ) begin add_simple(K_NOTEQ); mode = M_IDLE; end
            else begin add_simple(K_NOT); again = 1; end
         M_GT:
            if (c == CH_EQ) begin add_simple(K_GREATEREQ); mode = M_IDLE; end
            else begin add_simple(K_GREATER); again = 1; end
         M_IDENT:
            if (is_letter(c) || is_num(c)) append_text(c);
            else begin
               close_ident();
               again = (mode != M_HALT);
            end
         M_INT:
            if (is_num(c)) iacc = (iacc > (INT_TOP - d) / 10) ? INT_TOP : iacc * 10 + d;
            else if (c == CH_DOT) mode = M_DOT;
            else begin
               add_token(K_INT, iacc, 0, 0, 0, 0, E_NONE, 1);
               again = 1;
            end
         M_DOT:
            if (is_num(c)) begin
               facc = d;
               fcnt = 1;
               mode = M_FRAC;
            end else add_error(E_DOT);
         M_FRAC:
            if (is_num(c)) begin
               if (fcnt < 9) begin
                  facc = facc * 10 + d;
                  fcnt++;
               end
            end else begin
               add_token(K_REAL, iacc, facc, fcnt, 0, 0, E_NONE, 1);
               again = 1;
            end
         M_STR:
            if (c == CH_QUOTE) begin
               mode = M_IDLE;
               emit_text(K_STRING);
            end else if (c == CH_NUL) add_error(E_STRING);
            else append_text(c);
         default: again = 1;
      endcase
      if (again) scan_start(c);
   endtask

   // stimulus helpers
   task automatic put_str(string s);
      for (int i = 0; i < s.len(); i++) source_q.push_back(s[i]);
   endtask

   function automatic logic [CHAR_W-1:0] word_char(bit first);
      int r;
      r = $urandom_range(0, first ? 52 : 62);
      if (r < 26) return CHAR_W'("a" + r);
      if (r < 52) return CHAR_W'("A" + r - 26);
      if (r == 52) return CH_UNDER;
      return CHAR_W'("0" + r - 53);
   endfunction

   task automatic put_sep();
      case ($urandom_range(0, 4))
         0: source_q.push_back(CH_TAB);
         1: source_q.push_back(CH_NL);
         2: begin
            source_q.push_back(CH_CR);
            source_q.push_back(CH_NL);
         end
         3: source_q.push_back(CH_CR);
         default: source_q.push_back(CH_SPACE);
      endcase
   endtask

   task automatic put_digits(int n);
      for (int i = 0; i < n; i++) source_q.push_back(CHAR_W'("0" + $urandom_range(0, 9)));
   endtask

   task automatic put_ident(int n);
      for (int i = 0; i < n; i++) source_q.push_back(word_char(i == 0));
   endtask

   task automatic put_token();
      string ops[5] = '{"==", "!=", ">=", "&&", "||"};
      string singles = ",:;()+-*/<=!>";
      logic [CHAR_W-1:0] c;
      int n;
      case ($urandom_range(0, 11))
         0: begin put_str(kw_names[$urandom_range(0, 9)]); put_sep(); end
         1: begin
            put_ident($urandom_range(0, 9) == 0 ? TEXT_MAX : $urandom_range(1, 6));
            put_sep();
         end
         2: begin put_digits($urandom_range(0, 5) == 0 ? 11 : $urandom_range(1, 4)); put_sep(); end
         3: begin
            put_digits($urandom_range(1, 3));
            source_q.push_back(CH_DOT);
            put_digits($urandom_range(0, 5) == 0 ? 12 : $urandom_range(1, 4));
            put_sep();
         end
         4: begin
            n = $urandom_range(0, 9) == 0 ? TEXT_MAX : $urandom_range(0, 5);
            source_q.push_back(CH_QUOTE);
            for (int i = 0; i < n; i++) begin
               c = CHAR_W'($urandom_range(1, 255));
               source_q.push_back(c == CH_QUOTE ? 8'hA2 : c);
            end
            source_q.push_back(CH_QUOTE);
         end
         5: begin
            source_q.push_back(CH_HASH);
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) begin
               c = CHAR_W'($urandom_range(1, 255));
               source_q.push_back(c == CH_NL ? 8'h8A : c);
            end
            source_q.push_back($urandom_range(0, 3) == 0 ? CH_NUL : CH_NL);
         end
         6, 7: put_str(ops[$urandom_range(0, 4)]);
         8, 9: source_q.push_back(singles[$urandom_range(0, singles.len() - 1)]);
         10: source_q.push_back(CH_NUL);
         default: put_sep();
      endcase
   endtask

   // one error at the very end: the block halts until reset
   task automatic put_error_tail();
      case ($urandom_range(1, 6))
         1: begin put_ident(TEXT_MAX + 1); put_sep(); end
         2: put_str("& ");
         3: put_str("| ");
         4: put_str("5. ");
         5: begin put_str("\"ab"); source_q.push_back(CH_NUL); end
         default: put_str(".");
      endcase
      put_str("x=1;\"");
      source_q.push_back(CH_NUL);
   endtask

   function automatic int phase();
      return accepted * 4 / total_items;
   endfunction

   // driver
   bit pausing = 0, pause_done = 0, offer;

   always @(posedge clock) begin
      if (reset) begin
         push <= 0;
         req_char_in <= '0;
      end else begin
         offer = push && full;
         if (push && !full) begin
            lex_byte(req_char_in);
            void'(source_q.pop_front());
            accepted++;
         end
         if (accepted >= PAUSE_AT && !pause_done) begin
            pausing = 1;
            pause_done = 1;
         end
         if (pausing && token_q.size() == 0) pausing = 0;
         if (!offer && !pausing && source_q.size() != 0)
            offer = $urandom_range(0, 99) >= (phase() == 1 ? 51 : phase() == 3 ? 28 : 0);
         push <= offer && source_q.size() != 0;
         req_char_in <= source_q.size() != 0 ? source_q[0] : CH_NUL;
      end
   end

   // monitor
   int hold_cnt = 0;
   bit hold_done = 0;
   token_type exp_tok;

   task automatic report_mismatch(string field, longint got, longint want);
      errors++;
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, field, got, want);
   endtask

   always @(posedge clock) begin
      if (reset) pop <= 0;
      else begin
         if (pop && !empty) begin
            if (token_q.size() == 0) begin
               report_mismatch("unexpected kind", rsp_token_kind, 0);
            end else begin
               exp_tok = token_q.pop_front();
               if (rsp_token_kind !== exp_tok.kind)
                  report_mismatch("kind", rsp_token_kind, exp_tok.kind);
               if (rsp_line_number !== exp_tok.line)
                  report_mismatch("line", rsp_line_number, exp_tok.line);
               if (rsp_int_value !== exp_tok.ival)
                  report_mismatch("int", rsp_int_value, exp_tok.ival);
               if (rsp_fraction_value !== exp_tok.fval)
                  report_mismatch("fraction", rsp_fraction_value, exp_tok.fval);
               if (rsp_fraction_length !== exp_tok.flen)
                  report_mismatch("fraction_len", rsp_fraction_length, exp_tok.flen);
               if (rsp_text_char !== exp_tok.ch)
                  report_mismatch("char", rsp_text_char, exp_tok.ch);
               if (rsp_text_position !== exp_tok.pos)
                  report_mismatch("position", rsp_text_position, exp_tok.pos);
               if (rsp_error_code !== exp_tok.ec)
                  report_mismatch("error_code", rsp_error_code, exp_tok.ec);
               if (rsp_last_of_run !== exp_tok.last)
                  report_mismatch("last", rsp_last_of_run, exp_tok.last);
            end
         end
         if (accepted >= HOLD_AT && !hold_done) begin
            hold_done = 1;
            hold_cnt = HOLD_LEN;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            pop <= 0;
         end else
            pop <= $urandom_range(0, 99) >= (phase() == 2 ? 51 : phase() == 3 ? 28 : 0);
      end
   end

   // watchdog on progress
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      // operators, lookahead, empty string, saturation, long fraction, CR LF
      put_str("==!=>=&&||!x>1<=\"\"2147483648 0.1234567891");
      source_q.push_back(CH_CR);
      source_q.push_back(CH_NL);
      while (source_q.size() < ITEM_GOAL) put_token();
      put_error_tail();
      total_items = source_q.size();
      repeat (10) @(posedge clock);
      reset <= 0;
      do @(posedge clock); while (source_q.size() != 0 || push);
      while (token_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
